@@ design/mvn_pkg.sv @@
package mvn_pkg;

	localparam int KIND_W      = 2;
	localparam int FIELD_IDX_W = 12;
	localparam int FIELD_CRD_W = 20;
	localparam int Q_W         = 16;
	localparam int ACC_W       = 48;
	localparam int NORM_BITS   = 30;

	localparam logic [KIND_W-1:0] KIND_VERTEX   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TRIANGLE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ     = 2'd2;

	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic signed [Q_W-1:0] nx;
		logic signed [Q_W-1:0] ny;
		logic signed [Q_W-1:0] nz;
		logic                  degenerate;
	} norm_res_t;

endpackage

@@ design/mvn_in_if.sv @@
interface mvn_in_if;
	import mvn_pkg::*;

	logic                          valid;
	logic                          ready;
	logic [KIND_W-1:0]             kind;
	logic [FIELD_IDX_W-1:0]        vertex_index;
	logic signed [FIELD_CRD_W-1:0] coord_x;
	logic signed [FIELD_CRD_W-1:0] coord_y;
	logic signed [FIELD_CRD_W-1:0] coord_z;
	logic [FIELD_IDX_W-1:0]        corner_a;
	logic [FIELD_IDX_W-1:0]        corner_b;
	logic [FIELD_IDX_W-1:0]        corner_c;

	modport source (
		output valid, kind, vertex_index, coord_x, coord_y, coord_z,
			corner_a, corner_b, corner_c,
		input  ready
	);

	modport sink (
		input  valid, kind, vertex_index, coord_x, coord_y, coord_z,
			corner_a, corner_b, corner_c,
		output ready
	);

endinterface

@@ design/mvn_out_if.sv @@
interface mvn_out_if;
	import mvn_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [FIELD_IDX_W-1:0] read_index;
	logic signed [Q_W-1:0]  normal_x;
	logic signed [Q_W-1:0]  normal_y;
	logic signed [Q_W-1:0]  normal_z;
	logic                   degenerate;

	modport source (
		output valid, read_index, normal_x, normal_y, normal_z, degenerate,
		input  ready
	);

	modport sink (
		input  valid, read_index, normal_x, normal_y, normal_z, degenerate,
		output ready
	);

endinterface

@@ design/mvn_norm.sv @@
module mvn_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  mvn_pkg::acc_t      acc_x,
	input  mvn_pkg::acc_t      acc_y,
	input  mvn_pkg::acc_t      acc_z,
	output logic               done,
	output mvn_pkg::norm_res_t res
);
	import mvn_pkg::*;

	localparam int SQ_W = 2 * NORM_BITS;
	localparam int RT_W = SQ_W + 3;
	localparam int L_W  = NORM_BITS + 1;
	localparam int QB   = Q_W + 1;
	localparam int DV_W = L_W + QB;

	localparam logic [2:0] N_IDLE = 3'd0;
	localparam logic [2:0] N_NORM = 3'd1;
	localparam logic [2:0] N_SQ   = 3'd2;
	localparam logic [2:0] N_SQRT = 3'd3;
	localparam logic [2:0] N_DLD  = 3'd4;
	localparam logic [2:0] N_DIV  = 3'd5;
	localparam logic [2:0] N_FIN  = 3'd6;
	localparam logic [2:0] N_DONE = 3'd7;

	logic [2:0]            state_q;
	logic [1:0]            k_q;
	logic [4:0]            i_q;
	logic [ACC_W-1:0]      mx_q, my_q, mz_q;
	logic                  negx_q, negy_q, negz_q;
	logic [SQ_W-1:0]       sq_q;
	logic [RT_W-1:0]       sum_q;
	logic [RT_W-1:0]       rem_q;
	logic [RT_W-1:0]       root_q;
	logic [RT_W-1:0]       bit_q;
	logic [DV_W-1:0]       r_q;
	logic [QB-1:0]         q_q;
	logic signed [Q_W-1:0] rx_q, ry_q, rz_q;
	logic                  deg_q;

	logic [ACC_W-1:0]      or_v;
	logic [ACC_W-1:0]      msel;
	logic                  nsel;
	logic [L_W-1:0]        len;
	logic [RT_W-1:0]       trial;
	logic [DV_W-1:0]       dsub;
	logic [QB-1:0]         qsat;
	logic signed [Q_W-1:0] qout;

	function automatic logic [ACC_W-1:0] mag_of(input acc_t v);
		return v[ACC_W-1] ? (~v + 1'b1) : v;
	endfunction

	always_comb begin
		or_v  = mx_q | my_q | mz_q;
		len   = root_q[L_W-1:0];
		trial = root_q + bit_q;
		dsub  = DV_W'(len) << i_q;
		unique case (k_q)
			2'd0: begin msel = mx_q; nsel = negx_q; end
			2'd1: begin msel = my_q; nsel = negy_q; end
			default: begin msel = mz_q; nsel = negz_q; end
		endcase
		// negative side may reach full scale, positive side stops one short
		if (nsel) begin
			qsat = (q_q > QB'(32768)) ? QB'(32768) : q_q;
			qout = $signed(Q_W'(QB'(0) - qsat));
		end else begin
			qsat = (q_q > QB'(32767)) ? QB'(32767) : q_q;
			qout = $signed(qsat[Q_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			k_q     <= '0;
			i_q     <= '0;
		end else begin
			unique case (state_q)
				N_IDLE, N_DONE: begin
					if (start) begin
						state_q <= ((acc_x | acc_y | acc_z) == '0) ? N_DONE : N_NORM;
					end
				end
				N_NORM: begin
					if (!(|or_v[ACC_W-1:NORM_BITS]) && or_v[NORM_BITS-1]) begin
						state_q <= N_SQ;
						k_q     <= '0;
					end
				end
				N_SQ: begin
					if (k_q == 2'd3) begin
						state_q <= N_SQRT;
					end
					k_q <= k_q + 2'd1;
				end
				N_SQRT: begin
					if (bit_q == '0) begin
						state_q <= N_DLD;
						k_q     <= '0;
					end
				end
				N_DLD: begin
					state_q <= N_DIV;
					i_q     <= 5'(QB - 1);
				end
				N_DIV: begin
					if (i_q == '0) begin
						state_q <= N_FIN;
					end else begin
						i_q <= i_q - 5'd1;
					end
				end
				N_FIN: begin
					if (k_q == 2'd2) begin
						state_q <= N_DONE;
					end else begin
						state_q <= N_DLD;
					end
					k_q <= k_q + 2'd1;
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			N_IDLE, N_DONE: begin
				if (start) begin
					mx_q   <= mag_of(acc_x);
					my_q   <= mag_of(acc_y);
					mz_q   <= mag_of(acc_z);
					negx_q <= acc_x[ACC_W-1];
					negy_q <= acc_y[ACC_W-1];
					negz_q <= acc_z[ACC_W-1];
					rx_q   <= '0;
					ry_q   <= '0;
					rz_q   <= '0;
					deg_q  <= ((acc_x | acc_y | acc_z) == '0);
				end
			end
			N_NORM: begin
				// bring the largest magnitude to exactly NORM_BITS bits
				if (|or_v[ACC_W-1:NORM_BITS]) begin
					mx_q <= mx_q >> 1;
					my_q <= my_q >> 1;
					mz_q <= mz_q >> 1;
				end else if (!or_v[NORM_BITS-1]) begin
					mx_q <= mx_q << 1;
					my_q <= my_q << 1;
					mz_q <= mz_q << 1;
				end
			end
			N_SQ: begin
				if (k_q != 2'd3) begin
					sq_q <= msel[NORM_BITS-1:0] * msel[NORM_BITS-1:0];
				end
				unique case (k_q)
					2'd0: sum_q <= '0;
					2'd3: begin
						rem_q  <= sum_q + RT_W'(sq_q);
						root_q <= '0;
						bit_q  <= RT_W'(1) << (RT_W - 3);
					end
					default: sum_q <= sum_q + RT_W'(sq_q);
				endcase
			end
			N_SQRT: begin
				if (bit_q != '0) begin
					if (rem_q >= trial) begin
						rem_q  <= rem_q - trial;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			N_DLD: begin
				r_q <= DV_W'({msel[NORM_BITS-1:0], 15'd0}) + DV_W'(len >> 1);
				q_q <= '0;
			end
			N_DIV: begin
				if (r_q >= dsub) begin
					r_q      <= r_q - dsub;
					q_q[i_q] <= 1'b1;
				end
			end
			N_FIN: begin
				unique case (k_q)
					2'd0: rx_q <= qout;
					2'd1: ry_q <= qout;
					default: rz_q <= qout;
				endcase
			end
			default: ;
		endcase
	end

	assign done = (state_q == N_DONE);
	assign res  = '{nx: rx_q, ny: ry_q, nz: rz_q, degenerate: deg_q};

endmodule

@@ design/mesh_vertex_normal_engine.sv @@
// Area-weighted vertex normal engine.
// item channel: kind 0 stores a vertex and clears its normal sum, kind 1
// adds the cross product (p1-p0)x(p2-p0) of a triangle to the sums of its
// three corners, kind 2 reads one vertex normal scaled to unit length in
// Q1.15; kind 3 is dropped. Only kind 2 sends a transfer on the result
// channel (read_index echoes the field, degenerate flags an all-zero sum).
// Items are taken one at a time; ready is high only while the sequencer idles.
// A vertex write stores the point and its cleared sum together; a triangle
// does three vertex reads on the single vertex memory port, six products
// through one multiplier, then a read-modify-write of each corner on the
// sum memory; a normal read goes through the shift-by-one normalizer, the
// bit-pair square root and the three 17-bit quotients of the normalizer
// unit, all of which are skipped for an all-zero sum.
// After reset the sum memory is swept to zero, one entry per cycle, and
// ready stays low meanwhile.
// A finished result waits in an output register; the next item is taken
// while it waits, and a later read holds until the receiver takes it.
module mesh_vertex_normal_engine #(
	parameter int MAX_VERTICES = 4096,
	parameter int COORD_BITS   = 20
) (
	input logic clk,
	input logic arst_n,
	mvn_in_if.sink    item,
	mvn_out_if.source result
);
	import mvn_pkg::*;

	localparam int VX_W = $clog2(MAX_VERTICES);
	localparam int RW   = VX_W + 9;
	localparam int DW   = COORD_BITS + 1;
	localparam int PW   = 2 * DW;
	localparam int CW   = PW + 1;
	localparam int SW   = ((CW > ACC_W) ? CW : ACC_W) + 1;
	localparam int VM_W = 3 * COORD_BITS;
	localparam int AM_W = 3 * ACC_W;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_VWR   = 4'd2;
	localparam logic [3:0] S_TRD0  = 4'd3;
	localparam logic [3:0] S_TRD1  = 4'd4;
	localparam logic [3:0] S_TRD2  = 4'd5;
	localparam logic [3:0] S_TDIFF = 4'd6;
	localparam logic [3:0] S_TMUL  = 4'd7;
	localparam logic [3:0] S_TACC  = 4'd8;
	localparam logic [3:0] S_ARD   = 4'd9;
	localparam logic [3:0] S_AWB   = 4'd10;
	localparam logic [3:0] S_NRD   = 4'd11;
	localparam logic [3:0] S_NST   = 4'd12;
	localparam logic [3:0] S_NWAIT = 4'd13;

	logic [VM_W-1:0] vmem [MAX_VERTICES];
	logic [AM_W-1:0] amem [MAX_VERTICES];

	logic [3:0]             state_q;
	logic [VX_W-1:0]        clr_q;
	logic [1:0]             k_q;
	logic [2:0]             cnt_q;
	logic                   out_valid_q;
	logic [FIELD_IDX_W-1:0] out_idx_q;
	norm_res_t              out_res_q;

	logic [VX_W-1:0]        idx_q;
	logic [FIELD_IDX_W-1:0] echo_q;
	logic [COORD_BITS-1:0]  cx_q, cy_q, cz_q;
	logic [VX_W-1:0]        corner_q [3];
	logic [VM_W-1:0]        vrd_q;
	logic [AM_W-1:0]        ard_q;
	logic [VM_W-1:0]        p0_q, p1_q;
	logic signed [DW-1:0]   ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	logic signed [PW-1:0]   prod_q;
	logic signed [CW-1:0]   n_q [3];

	logic                   accept;
	logic                   out_free;
	logic                   vwe;
	logic                   awe;
	logic [VX_W-1:0]        awaddr;
	logic [AM_W-1:0]        awdata;
	logic [VX_W-1:0]        araddr;
	logic [VX_W-1:0]        vraddr;
	logic signed [DW-1:0]   ma, mb;
	logic signed [PW-1:0]   prod_c;
	logic signed [CW-1:0]   prod_ext;
	logic                   nu_start;
	logic                   nu_done;
	norm_res_t              nu_res;

	function automatic logic [VX_W-1:0] reduce_idx(input logic [FIELD_IDX_W-1:0] v);
		logic [RW-1:0] r;
		r = RW'(v);
		for (int k = 7; k >= 0; k--) begin
			if (r >= (RW'(MAX_VERTICES) << k)) begin
				r = r - (RW'(MAX_VERTICES) << k);
			end
		end
		return r[VX_W-1:0];
	endfunction

	function automatic logic signed [DW-1:0] sx(input logic [COORD_BITS-1:0] c);
		return $signed({c[COORD_BITS-1], c});
	endfunction

	function automatic logic [ACC_W-1:0] sat_add(input acc_t a, input logic signed [CW-1:0] b);
		logic signed [SW-1:0] s;
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		s  = SW'(a) + SW'(b);
		hi = {{(SW-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
		lo = ~hi;
		if (s > hi) begin
			return hi[ACC_W-1:0];
		end else if (s < lo) begin
			return lo[ACC_W-1:0];
		end
		return s[ACC_W-1:0];
	endfunction

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	assign result.valid      = out_valid_q;
	assign result.read_index = out_idx_q;
	assign result.normal_x   = out_res_q.nx;
	assign result.normal_y   = out_res_q.ny;
	assign result.normal_z   = out_res_q.nz;
	assign result.degenerate = out_res_q.degenerate;

	always_comb begin
		vwe      = (state_q == S_VWR);
		vraddr   = corner_q[k_q];
		araddr   = (state_q == S_ARD) ? corner_q[k_q] : idx_q;
		nu_start = (state_q == S_NST);
		awe      = 1'b0;
		awaddr   = idx_q;
		awdata   = '0;
		unique case (state_q)
			S_CLEAR: begin
				awe    = 1'b1;
				awaddr = clr_q;
			end
			S_VWR: awe = 1'b1;
			S_AWB: begin
				awe    = 1'b1;
				awaddr = corner_q[k_q];
				awdata = {sat_add(ard_q[3*ACC_W-1:2*ACC_W], n_q[2]),
					sat_add(ard_q[2*ACC_W-1:ACC_W], n_q[1]),
					sat_add(ard_q[ACC_W-1:0], n_q[0])};
			end
			default: ;
		endcase
		unique case (cnt_q)
			3'd0: begin ma = ay_q; mb = bz_q; end
			3'd1: begin ma = az_q; mb = by_q; end
			3'd2: begin ma = az_q; mb = bx_q; end
			3'd3: begin ma = ax_q; mb = bz_q; end
			3'd4: begin ma = ax_q; mb = by_q; end
			default: begin ma = ay_q; mb = bx_q; end
		endcase
		prod_c   = ma * mb;
		prod_ext = $signed({prod_q[PW-1], prod_q});
	end

	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[idx_q] <= {cz_q, cy_q, cx_q};
		end
		vrd_q <= vmem[vraddr];
	end

	always_ff @(posedge clk) begin
		if (awe) begin
			amem[awaddr] <= awdata;
		end
		ard_q <= amem[araddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == VX_W'(MAX_VERTICES - 1)) begin
						state_q <= S_IDLE;
					end
					clr_q <= clr_q + 1'b1;
				end
				S_IDLE: begin
					k_q   <= '0;
					cnt_q <= '0;
					if (accept) begin
						unique case (item.kind)
							KIND_VERTEX:   state_q <= S_VWR;
							KIND_TRIANGLE: state_q <= S_TRD0;
							KIND_READ:     state_q <= S_NRD;
							default:       state_q <= S_IDLE;
						endcase
					end
				end
				S_VWR: state_q <= S_IDLE;
				S_TRD0: begin
					state_q <= S_TRD1;
					k_q     <= 2'd1;
				end
				S_TRD1: begin
					state_q <= S_TRD2;
					k_q     <= 2'd2;
				end
				S_TRD2: state_q <= S_TDIFF;
				S_TDIFF: state_q <= S_TMUL;
				S_TMUL: state_q <= S_TACC;
				S_TACC: begin
					if (cnt_q == 3'd5) begin
						state_q <= S_ARD;
						k_q     <= '0;
					end else begin
						state_q <= S_TMUL;
						cnt_q   <= cnt_q + 3'd1;
					end
				end
				S_ARD: state_q <= S_AWB;
				S_AWB: begin
					// write lands before the next corner is read, so repeats add twice
					if (k_q == 2'd2) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ARD;
						k_q     <= k_q + 2'd1;
					end
				end
				S_NRD: state_q <= S_NST;
				S_NST: state_q <= S_NWAIT;
				S_NWAIT: begin
					if (nu_done && out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q       <= reduce_idx(item.vertex_index);
			echo_q      <= item.vertex_index;
			cx_q        <= item.coord_x[COORD_BITS-1:0];
			cy_q        <= item.coord_y[COORD_BITS-1:0];
			cz_q        <= item.coord_z[COORD_BITS-1:0];
			corner_q[0] <= reduce_idx(item.corner_a);
			corner_q[1] <= reduce_idx(item.corner_b);
			corner_q[2] <= reduce_idx(item.corner_c);
		end
		if (state_q == S_TRD1) begin
			p0_q <= vrd_q;
		end
		if (state_q == S_TRD2) begin
			p1_q <= vrd_q;
		end
		if (state_q == S_TDIFF) begin
			ax_q <= sx(p1_q[COORD_BITS-1:0]) - sx(p0_q[COORD_BITS-1:0]);
			ay_q <= sx(p1_q[2*COORD_BITS-1:COORD_BITS]) - sx(p0_q[2*COORD_BITS-1:COORD_BITS]);
			az_q <= sx(p1_q[VM_W-1:2*COORD_BITS]) - sx(p0_q[VM_W-1:2*COORD_BITS]);
			bx_q <= sx(vrd_q[COORD_BITS-1:0]) - sx(p0_q[COORD_BITS-1:0]);
			by_q <= sx(vrd_q[2*COORD_BITS-1:COORD_BITS]) - sx(p0_q[2*COORD_BITS-1:COORD_BITS]);
			bz_q <= sx(vrd_q[VM_W-1:2*COORD_BITS]) - sx(p0_q[VM_W-1:2*COORD_BITS]);
		end
		if (state_q == S_TMUL) begin
			prod_q <= prod_c;
		end
		if (state_q == S_TACC) begin
			// even steps load a component, odd steps subtract the second product
			if (!cnt_q[0]) begin
				n_q[cnt_q[2:1]] <= prod_ext;
			end else begin
				n_q[cnt_q[2:1]] <= n_q[cnt_q[2:1]] - prod_ext;
			end
		end
		if (state_q == S_NWAIT && nu_done && out_free) begin
			out_idx_q <= echo_q;
			out_res_q <= nu_res;
		end
	end

	mvn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (nu_start),
		.acc_x  (ard_q[ACC_W-1:0]),
		.acc_y  (ard_q[2*ACC_W-1:ACC_W]),
		.acc_z  (ard_q[3*ACC_W-1:2*ACC_W]),
		.done   (nu_done),
		.res    (nu_res)
	);

endmodule

@@ tb/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mvn_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int SLOTS = 4096;
	localparam int POOL = 24;
	localparam int RANDOM_ITEMS = 380;
	localparam int SAT_SLOT = 4000;
	localparam int SAT_REPEAT = 140;
	localparam int STALL_LIMIT = 20000;
	localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam logic signed [FIELD_CRD_W-1:0] CRD_MAX = 20'sh7FFFF;
	localparam logic signed [FIELD_CRD_W-1:0] CRD_MIN = 20'sh80000;

	typedef struct packed {
		logic [KIND_W-1:0]             kind;
		logic [FIELD_IDX_W-1:0]        vi;
		logic signed [FIELD_CRD_W-1:0] x;
		logic signed [FIELD_CRD_W-1:0] y;
		logic signed [FIELD_CRD_W-1:0] z;
		logic [FIELD_IDX_W-1:0]        a;
		logic [FIELD_IDX_W-1:0]        b;
		logic [FIELD_IDX_W-1:0]        c;
	} mesh_item_t;

	typedef struct packed {
		logic [FIELD_IDX_W-1:0] idx;
		logic signed [Q_W-1:0]  nx;
		logic signed [Q_W-1:0]  ny;
		logic signed [Q_W-1:0]  nz;
		logic                   degenerate;
	} normal_t;

	typedef struct {
		mesh_item_t it;
		bit         typed;
		normal_t    want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	mvn_in_if  item();
	mvn_out_if result();

	mesh_vertex_normal_engine i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source)
	);

	// predictor state
	longint vtx [SLOTS][3];
	longint sum_x [SLOTS];
	longint sum_y [SLOTS];
	longint sum_z [SLOTS];
	bit written [SLOTS];
	int written_list [$];
	int pool [POOL];

	normal_t pending_normals [$];
	plan_row_t plan [$];
	int errors;
	bit gaps_on;
	int stall_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint sat_sum(longint acc, longint inc);
		longint s;
		s = acc + inc;
		if (s > ACC_HI) return ACC_HI;
		if (s < ACC_LO) return ACC_LO;
		return s;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned s);
		longint unsigned r;
		longint unsigned bit_w;
		r = 0;
		bit_w = 64'h1 << 62;
		while (bit_w > s) bit_w >>= 2;
		while (bit_w != 0) begin
			if (s >= r + bit_w) begin
				s -= r + bit_w;
				r = (r >> 1) + bit_w;
			end else begin
				r >>= 1;
			end
			bit_w >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [Q_W-1:0] unit_q15(bit neg, longint unsigned mag,
			longint unsigned len);
		longint unsigned q;
		q = ((mag << 15) + (len >> 1)) / len;
		if (neg) begin
			if (q > 32768) q = 32768;
			return -q[Q_W-1:0];
		end
		if (q > 32767) q = 32767;
		return q[Q_W-1:0];
	endfunction

	function automatic longint unsigned mag_of(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic normal_t normal_of(logic [FIELD_IDX_W-1:0] idx);
		normal_t n;
		longint unsigned mx, my, mz, m, len;
		int bl;
		n.idx = idx;
		mx = mag_of(sum_x[idx]);
		my = mag_of(sum_y[idx]);
		mz = mag_of(sum_z[idx]);
		m = mx;
		if (my > m) m = my;
		if (mz > m) m = mz;
		if (m == 0) begin
			n.nx = '0; n.ny = '0; n.nz = '0; n.degenerate = 1'b1;
			return n;
		end
		bl = 0;
		while (m != 0) begin bl++; m >>= 1; end
		if (bl > NORM_BITS) begin
			mx >>= bl - NORM_BITS; my >>= bl - NORM_BITS; mz >>= bl - NORM_BITS;
		end else begin
			mx <<= NORM_BITS - bl; my <<= NORM_BITS - bl; mz <<= NORM_BITS - bl;
		end
		len = root_floor(mx * mx + my * my + mz * mz);
		n.nx = unit_q15(sum_x[idx] < 0, mx, len);
		n.ny = unit_q15(sum_y[idx] < 0, my, len);
		n.nz = unit_q15(sum_z[idx] < 0, mz, len);
		n.degenerate = 1'b0;
		return n;
	endfunction

	// advance the predictor by one accepted item
	task automatic apply_item(mesh_item_t it, bit typed, normal_t want);
		longint ax, ay, az, bx, by, bz, cx, cy, cz;
		int cr [3];
		case (it.kind)
			KIND_VERTEX: begin
				vtx[it.vi][0] = it.x;
				vtx[it.vi][1] = it.y;
				vtx[it.vi][2] = it.z;
				sum_x[it.vi] = 0; sum_y[it.vi] = 0; sum_z[it.vi] = 0;
				if (!written[it.vi]) written_list.push_back(int'(it.vi));
				written[it.vi] = 1'b1;
			end
			KIND_TRIANGLE: begin
				cr[0] = int'(it.a); cr[1] = int'(it.b); cr[2] = int'(it.c);
				ax = vtx[cr[1]][0] - vtx[cr[0]][0];
				ay = vtx[cr[1]][1] - vtx[cr[0]][1];
				az = vtx[cr[1]][2] - vtx[cr[0]][2];
				bx = vtx[cr[2]][0] - vtx[cr[0]][0];
				by = vtx[cr[2]][1] - vtx[cr[0]][1];
				bz = vtx[cr[2]][2] - vtx[cr[0]][2];
				cx = ay * bz - az * by;
				cy = az * bx - ax * bz;
				cz = ax * by - ay * bx;
				foreach (cr[k]) begin
					sum_x[cr[k]] = sat_sum(sum_x[cr[k]], cx);
					sum_y[cr[k]] = sat_sum(sum_y[cr[k]], cy);
					sum_z[cr[k]] = sat_sum(sum_z[cr[k]], cz);
				end
			end
			KIND_READ: pending_normals.push_back(typed ? want : normal_of(it.vi));
			default: ;
		endcase
	endtask

	// drive one item, hold it until the transfer, then update the predictor
	task automatic send_item(mesh_item_t it, bit typed = 1'b0, normal_t want = '0);
		while (gaps_on && $urandom_range(99) < 26) begin
			item.valid <= 1'b0;
			@(posedge clk);
		end
		item.valid        <= 1'b1;
		item.kind         <= it.kind;
		item.vertex_index <= it.vi;
		item.coord_x      <= it.x;
		item.coord_y      <= it.y;
		item.coord_z      <= it.z;
		item.corner_a     <= it.a;
		item.corner_b     <= it.b;
		item.corner_c     <= it.c;
		forever begin
			@(negedge clk);
			if (item.ready) break;
		end
		apply_item(it, typed, want);
		@(posedge clk);
	endtask

	function automatic mesh_item_t make_item(logic [KIND_W-1:0] kind, int vi,
			int x, int y, int z, int a, int b, int c);
		mesh_item_t it;
		it.kind = kind; it.vi = FIELD_IDX_W'(vi);
		it.x = FIELD_CRD_W'(x); it.y = FIELD_CRD_W'(y); it.z = FIELD_CRD_W'(z);
		it.a = FIELD_IDX_W'(a); it.b = FIELD_IDX_W'(b); it.c = FIELD_IDX_W'(c);
		return it;
	endfunction

	function automatic logic signed [FIELD_CRD_W-1:0] rand_coord();
		case ($urandom_range(9))
			0: return CRD_MAX;
			1: return CRD_MIN;
			2, 3, 4: return FIELD_CRD_W'($urandom);
			default: return FIELD_CRD_W'($signed($urandom_range(8191)) - 4096);
		endcase
	endfunction

	function automatic mesh_item_t rand_noise();
		mesh_item_t it;
		it.kind = KIND_VERTEX; it.vi = FIELD_IDX_W'($urandom);
		it.x = FIELD_CRD_W'($urandom);
		it.y = FIELD_CRD_W'($urandom);
		it.z = FIELD_CRD_W'($urandom);
		it.a = FIELD_IDX_W'($urandom);
		it.b = FIELD_IDX_W'($urandom);
		it.c = FIELD_IDX_W'($urandom);
		return it;
	endfunction

	function automatic int pick_written();
		int idx;
		if ($urandom_range(99) < 80) begin
			idx = pool[$urandom_range(POOL - 1)];
			if (written[idx]) return idx;
		end
		return written_list[$urandom_range(written_list.size() - 1)];
	endfunction

	task automatic add_row(mesh_item_t it);
		plan_row_t r;
		r.it = it; r.typed = 1'b0; r.want = '0;
		plan.push_back(r);
	endtask

	task automatic add_typed(mesh_item_t it, normal_t want);
		plan_row_t r;
		r.it = it; r.typed = 1'b1; r.want = want;
		plan.push_back(r);
	endtask

	task automatic run_random();
		mesh_item_t it;
		int sel, idx;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			gaps_on = !(n >= 200 && n < 300);
			if (n == 300) begin
				// hold off until every pending normal has come back
				item.valid <= 1'b0;
				while (pending_normals.size() != 0) @(posedge clk);
			end
			if (n == 100) begin
				// push three corners past the positive sum limit
				send_item(make_item(KIND_VERTEX, SAT_SLOT, CRD_MIN, CRD_MIN, CRD_MIN,
					0, 0, 0));
				send_item(make_item(KIND_VERTEX, SAT_SLOT + 1, CRD_MAX, CRD_MIN, CRD_MIN,
					0, 0, 0));
				send_item(make_item(KIND_VERTEX, SAT_SLOT + 2, CRD_MIN, CRD_MAX, CRD_MIN,
					0, 0, 0));
				repeat (SAT_REPEAT) send_item(make_item(KIND_TRIANGLE, 0, 0, 0, 0,
					SAT_SLOT, SAT_SLOT + 1, SAT_SLOT + 2));
				for (int k = 0; k < 3; k++)
					send_item(make_item(KIND_READ, SAT_SLOT + k, 0, 0, 0, 0, 0, 0));
			end
			it = rand_noise();
			sel = $urandom_range(99);
			if (sel < 3) begin
				it.kind = KIND_UNUSED;
				send_item(it);
			end else if (sel < 30) begin
				if ($urandom_range(99) < 70)
					it.vi = FIELD_IDX_W'(pool[$urandom_range(POOL - 1)]);
				it.x = rand_coord(); it.y = rand_coord(); it.z = rand_coord();
				send_item(it);
			end else if (sel < 76) begin
				it.kind = KIND_TRIANGLE;
				it.a = FIELD_IDX_W'(pick_written());
				it.b = FIELD_IDX_W'(pick_written());
				it.c = FIELD_IDX_W'(pick_written());
				send_item(it);
			end else begin
				it.kind = KIND_READ;
				idx = $urandom_range(99) < 70 ? pool[$urandom_range(POOL - 1)] : $urandom;
				it.vi = FIELD_IDX_W'(idx);
				send_item(it);
			end
		end
	endtask

	// result side: random stall, check each transfer against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			result.ready <= gaps_on ? ($urandom_range(99) >= 26) : 1'b1;
		end
	end

	always @(negedge clk) begin
		normal_t got, exp_n;
		if (arst_n && result.valid && result.ready) begin
			got.idx = result.read_index;
			got.nx = result.normal_x;
			got.ny = result.normal_y;
			got.nz = result.normal_z;
			got.degenerate = result.degenerate;
			if (pending_normals.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result idx=%0d", got.idx);
			end else begin
				exp_n = pending_normals.pop_front();
				if (got !== exp_n) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch exp idx=%0d n=(%0d,%0d,%0d) d=%0b",
							" got idx=%0d n=(%0d,%0d,%0d) d=%0b"},
							exp_n.idx, exp_n.nx, exp_n.ny, exp_n.nz, exp_n.degenerate,
							got.idx, got.nx, got.ny, got.nz, got.degenerate);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(negedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		normal_t flat, up, down;
		errors = 0;
		stall_cycles = 0;
		gaps_on = 1'b1;
		arst_n <= 1'b0;
		item.valid <= 1'b0;
		item.kind <= KIND_VERTEX;
		item.vertex_index <= '0;
		item.coord_x <= '0;
		item.coord_y <= '0;
		item.coord_z <= '0;
		item.corner_a <= '0;
		item.corner_b <= '0;
		item.corner_c <= '0;
		pool[0] = 0;
		pool[1] = SLOTS - 1;
		for (int k = 2; k < POOL; k++) pool[k] = $urandom_range(SLOTS - 1);
		foreach (sum_x[k]) begin
			sum_x[k] = 0; sum_y[k] = 0; sum_z[k] = 0; written[k] = 1'b0;
		end

		flat = '{idx: 0, nx: 0, ny: 0, nz: 0, degenerate: 1'b1};
		add_typed(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0), flat);
		flat.idx = 4095;
		add_typed(make_item(KIND_READ, 4095, 0, 0, 0, 0, 0, 0), flat);
		add_row(make_item(KIND_VERTEX, 0, 0, 0, 0, 0, 0, 0));
		add_row(make_item(KIND_VERTEX, 1, 256, 0, 0, 0, 0, 0));
		add_row(make_item(KIND_VERTEX, 2, 0, 256, 0, 0, 0, 0));
		add_row(make_item(KIND_TRIANGLE, 0, 0, 0, 0, 0, 1, 2));
		up = '{idx: 0, nx: 0, ny: 0, nz: 32767, degenerate: 1'b0};
		add_typed(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0), up);
		// opposite winding cancels the sum exactly
		add_row(make_item(KIND_TRIANGLE, 0, 0, 0, 0, 0, 2, 1));
		flat.idx = 1;
		add_typed(make_item(KIND_READ, 1, 0, 0, 0, 0, 0, 0), flat);
		add_row(make_item(KIND_TRIANGLE, 0, 0, 0, 0, 0, 2, 1));
		down = '{idx: 2, nx: 0, ny: 0, nz: -32768, degenerate: 1'b0};
		add_typed(make_item(KIND_READ, 2, 0, 0, 0, 0, 0, 0), down);
		add_row(make_item(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom));
		add_row(make_item(KIND_VERTEX, 4095, CRD_MAX, CRD_MAX, CRD_MAX, 0, 0, 0));
		add_row(make_item(KIND_VERTEX, 4094, CRD_MIN, CRD_MIN, CRD_MIN, 0, 0, 0));
		add_row(make_item(KIND_VERTEX, 4093, CRD_MAX, CRD_MIN, 0, 0, 0, 0));
		add_row(make_item(KIND_TRIANGLE, 0, 0, 0, 0, 4095, 4094, 4093));
		// repeated corner: zero area, added twice
		add_row(make_item(KIND_TRIANGLE, 0, 0, 0, 0, 4095, 4095, 4094));
		add_row(make_item(KIND_READ, 4095, 0, 0, 0, 0, 0, 0));
		add_row(make_item(KIND_READ, 4094, 0, 0, 0, 0, 0, 0));
		add_row(make_item(KIND_READ, 4093, 0, 0, 0, 0, 0, 0));
		add_row(make_item(KIND_VERTEX, 0, 0, 0, 0, 0, 0, 0));
		flat.idx = 0;
		add_typed(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0), flat);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) send_item(plan[k].it, plan[k].typed, plan[k].want);
		run_random();
		item.valid <= 1'b0;

		while (pending_normals.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
design/mvn_pkg.sv
design/mvn_in_if.sv
design/mvn_out_if.sv
design/mvn_norm.sv
design/mesh_vertex_normal_engine.sv
tb/testbench.sv
